[rtl/core/assert_macros.svh]
// Assertion macros for the RTL; only the translator module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/sc2a_pkg.sv]
`default_nettype none

package sc2a_pkg;

  localparam int unsigned KEYMAP_DEPTH = 128;
  localparam int unsigned ROM_FILLED   = 59;

  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_CAPS   = 8'h3A;
  localparam logic [7:0] SC_BREAK  = 8'h80;
  localparam logic [6:0] CASE_BIT  = 7'd32;

  localparam logic [6:0] PLAIN_MAP [ROM_FILLED] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
    7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
    7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F,
    7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  localparam logic [6:0] SHIFTED_MAP [ROM_FILLED] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
    7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
    7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F,
    7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

endpackage

`default_nettype wire

[rtl/core/scancode_to_ascii_translator.sv]
// Each accepted result is registered in the result register, or in the skid
// register while the output is stalled. Throughput: one scancode per cycle
// while the skid register is empty; the two-entry buffer takes one more input
// transfer while a result waits to be taken, then in_ready drops.
// Reset (synchronous, active high) empties the buffer and clears the shift
// and caps-lock flags.
`default_nettype none

`include "assert_macros.svh"

module scancode_to_ascii_translator #(
  parameter int unsigned KEYMAP_DEPTH = sc2a_pkg::KEYMAP_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] scan_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [6:0] ascii_char,
  output logic            char_valid
);

  logic       shift_held;
  logic       caps_active;
  logic       shift_next;
  logic       caps_next;
  logic       skid_valid;
  logic [6:0] skid_char;
  logic       skid_char_valid;
  logic [6:0] result_char;
  logic [6:0] rom_char;
  logic [5:0] rom_index;
  logic       accept;
  logic       out_free;
  logic       in_rom;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign rom_index = scan_code[5:0];
  assign in_rom    = (scan_code < 8'(sc2a_pkg::ROM_FILLED)) &&
                     ({1'b0, scan_code} < 9'(KEYMAP_DEPTH));

  always_comb begin
    rom_char = shift_held ? sc2a_pkg::SHIFTED_MAP[rom_index]
                          : sc2a_pkg::PLAIN_MAP[rom_index];
    shift_next  = shift_held;
    caps_next   = caps_active;
    result_char = '0;
    if (scan_code == sc2a_pkg::SC_LSHIFT || scan_code == sc2a_pkg::SC_RSHIFT) begin
      shift_next = 1'b1;
    end else if (scan_code == (sc2a_pkg::SC_LSHIFT | sc2a_pkg::SC_BREAK) ||
                 scan_code == (sc2a_pkg::SC_RSHIFT | sc2a_pkg::SC_BREAK)) begin
      shift_next = 1'b0;
    end else if (scan_code == sc2a_pkg::SC_CAPS) begin
      caps_next = !caps_active;
    end else if ((scan_code & sc2a_pkg::SC_BREAK) == 8'h00 && in_rom) begin
      result_char = rom_char;
      if (caps_active && ((rom_char >= 7'h61 && rom_char <= 7'h7A) ||
          (!shift_held && rom_char >= 7'h41 && rom_char <= 7'h5A))) begin
        result_char = rom_char ^ sc2a_pkg::CASE_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      caps_active <= 1'b0;
      out_valid   <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (accept) begin
        shift_held  <= shift_next;
        caps_active <= caps_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          ascii_char <= skid_char;
          char_valid <= skid_char_valid;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= accept;
          ascii_char <= result_char;
          char_valid <= (result_char != 7'd0);
        end
      end else if (accept) begin
        skid_valid      <= 1'b1;
        skid_char       <= result_char;
        skid_char_valid <= (result_char != 7'd0);
      end
    end
  end

  `ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full while output empty")
  `ASSERT_IMPL(a_char_valid_match, clk, rst, out_valid, char_valid == (ascii_char != 7'd0), "char_valid disagrees with ascii_char")
  `ASSERT_NEXT(a_caps_toggle, clk, rst, accept && scan_code == sc2a_pkg::SC_CAPS, caps_active != $past(caps_active), "caps lock did not toggle")
  `ASSERT_NEXT(a_shift_make, clk, rst, accept && scan_code == sc2a_pkg::SC_LSHIFT, shift_held, "shift make did not set shift")
  `ASSERT_NEXT(a_shift_break, clk, rst, accept && scan_code == (sc2a_pkg::SC_RSHIFT | sc2a_pkg::SC_BREAK), !shift_held, "shift break did not clear shift")

endmodule

`default_nettype wire

[bench/keymap_checker.sv]
module keymap_checker
  import sc2a_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] scan_code,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [6:0] ascii_char,
  input  wire logic       char_valid,
  output int              pending,
  output int              errors
);

  localparam logic [6:0] ASCII_NUL = 7'd0;
  localparam logic [6:0] ASCII_BS  = 7'd8;
  localparam logic [6:0] ASCII_TAB = 7'd9;
  localparam logic [6:0] ASCII_LF  = 7'd10;
  localparam logic [6:0] ASCII_ESC = 7'd27;

  typedef struct packed {
    logic [6:0] ch;
    logic       vld;
  } char_result_t;

  char_result_t awaited_chars[$];
  logic [6:0]   plain_keys   [ROM_FILLED];
  logic [6:0]   shifted_keys [ROM_FILLED];
  logic         shift_held = 1'b0;
  logic         caps_on    = 1'b0;
  int           fail_tally = 0;

  initial begin
    string plain_row;
    string shifted_row;
    int    blanks [6] = '{0, 29, 42, 54, 56, 58};
    // Spaces stand in for the entries that are patched below; the one at index 57 is the space key itself.
    plain_row   = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./ *   ";
    shifted_row = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>? *   ";
    for (int i = 0; i < ROM_FILLED; i++) begin
      plain_keys[i]   = 7'(plain_row[i]);
      shifted_keys[i] = 7'(shifted_row[i]);
    end
    foreach (blanks[i]) begin
      plain_keys[blanks[i]]   = ASCII_NUL;
      shifted_keys[blanks[i]] = ASCII_NUL;
    end
    plain_keys[1]  = ASCII_ESC;
    plain_keys[14] = ASCII_BS;
    plain_keys[15] = ASCII_TAB;
    plain_keys[28] = ASCII_LF;
    shifted_keys[1]  = ASCII_ESC;
    shifted_keys[14] = ASCII_BS;
    shifted_keys[15] = ASCII_TAB;
    shifted_keys[28] = ASCII_LF;
  end

  function automatic logic [6:0] translate_code(input logic [7:0] code);
    logic [6:0] c;
    c = ASCII_NUL;
    if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      shift_held = 1'b1;
    end else if (code == (SC_LSHIFT | SC_BREAK) || code == (SC_RSHIFT | SC_BREAK)) begin
      shift_held = 1'b0;
    end else if (code == SC_CAPS) begin
      caps_on = !caps_on;
    end else if ((code & SC_BREAK) == 8'd0 && code < ROM_FILLED && code < KEYMAP_DEPTH) begin
      c = shift_held ? shifted_keys[code] : plain_keys[code];
      // Caps lock flips lower-case letters to upper case; it flips upper-case letters only when shift is not held.
      if (caps_on && ((c >= "a" && c <= "z") || (!shift_held && c >= "A" && c <= "Z")))
        c = c ^ CASE_BIT;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    char_result_t due;
    logic [6:0]   ch;
    if (rst) begin
      shift_held = 1'b0;
      caps_on    = 1'b0;
      awaited_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_chars.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got ascii_char %h char_valid %b",
                   $time, ascii_char, char_valid);
          fail_tally++;
        end else begin
          due = awaited_chars.pop_front();
          if (ascii_char !== due.ch) begin
            $display("%0t: ascii_char expected %h, got %h", $time, due.ch, ascii_char);
            fail_tally++;
          end
          if (char_valid !== due.vld) begin
            $display("%0t: char_valid expected %b, got %b", $time, due.vld, char_valid);
            fail_tally++;
          end
        end
      end
      if (in_valid && in_ready) begin
        ch      = translate_code(scan_code);
        due.ch  = ch;
        due.vld = (ch != ASCII_NUL);
        awaited_chars.push_back(due);
      end
    end
    pending <= awaited_chars.size();
    errors  <= fail_tally;
  end

endmodule

[bench/tb_scancode_to_ascii_translator.sv]
module tb_scancode_to_ascii_translator;
  import sc2a_pkg::*;

  localparam int ITEM_TARGET = 750;
  localparam int IDLE_LIMIT  = 1000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] scan_code = 8'd0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [6:0] ascii_char;
  wire        char_valid;

  int pending;
  int errors;
  int sent        = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit send_calm   = 1'b0;
  bit take_calm   = 1'b0;

  always #6 clk = ~clk;

  scancode_to_ascii_translator DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .scan_code  (scan_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .char_valid (char_valid)
  );

  keymap_checker verifier (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .scan_code  (scan_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .char_valid (char_valid),
    .pending    (pending),
    .errors     (errors)
  );

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(ROM_FILLED, 127));
    return 8'($urandom_range(0, ROM_FILLED - 1));
  endfunction

  task automatic send_code(input logic [7:0] code);
    int gap;
    if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    scan_code <= code;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic key_stroke(input logic [7:0] code);
    send_code(code);
    send_code(code | SC_BREAK);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 79) == 0) take_calm <= !take_calm;
      stall_left <= pick_gap(take_calm);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] opening [26] = '{
      8'h1E, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h3B, SC_CAPS, 8'h1E, 8'h02,
      SC_LSHIFT, 8'h1E, 8'h02, SC_RSHIFT, SC_LSHIFT | SC_BREAK, 8'h10,
      SC_CAPS | SC_BREAK, SC_CAPS, 8'h1C, 8'h39, 8'h01, 8'h2B, 8'h29,
      8'h9E, SC_LSHIFT, 8'h33, SC_RSHIFT | SC_BREAK
    };
    logic [7:0] held;
    int         r;
    int         n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_code(opening[i]);

    // Mostly realistic typing: key press and release pairs, shifted runs
    // and caps-lock taps, mixed with raw noise bytes.
    while (sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_code(8'($urandom_range(0, 255)));
      end else if (r < 22) begin
        held = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
        send_code(held);
        n = $urandom_range(1, 4);
        repeat (n) key_stroke(pick_key());
        if ($urandom_range(0, 3) == 0) held = held ^ (SC_LSHIFT ^ SC_RSHIFT);
        send_code(held | SC_BREAK);
      end else if (r < 28) begin
        key_stroke(SC_CAPS);
      end else begin
        key_stroke(pick_key());
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sc2a_pkg.sv
rtl/core/scancode_to_ascii_translator.sv
bench/keymap_checker.sv
bench/tb_scancode_to_ascii_translator.sv
